// ===== src/avt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avt_pkg
// Shared types, constants and binary32 helper functions for the affine
// vector transform pipeline.
// ----------------------------------------------------------------------------
package avt_pkg;

  localparam int MW         = 51;
  localparam int EW         = 11;
  localparam int ADD_LAT    = 4;
  localparam int PIPE_DEPTH = 18;
  localparam int CFG_IW     = 3;
  localparam int NUM_MAT    = 6;

  localparam logic [CFG_IW-1:0] REG_ROW0_C01 = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ROW0_C23 = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ROW1_C01 = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ROW1_C23 = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ROW2_C01 = 3'd4;
  localparam logic [CFG_IW-1:0] REG_ROW2_C23 = 3'd5;
  localparam logic [CFG_IW-1:0] REG_MODE     = 3'd6;

  localparam logic [63:0] RST_ROW0_C01 = 64'h0000_0000_3F80_0000;
  localparam logic [63:0] RST_ROW0_C23 = 64'h0;
  localparam logic [63:0] RST_ROW1_C01 = 64'h3F80_0000_0000_0000;
  localparam logic [63:0] RST_ROW1_C23 = 64'h0;
  localparam logic [63:0] RST_ROW2_C01 = 64'h0;
  localparam logic [63:0] RST_ROW2_C23 = 64'h0000_0000_3F80_0000;

  localparam logic [1:0] MODE_PLAIN        = 2'd0;
  localparam logic [1:0] MODE_FUSED        = 2'd1;
  localparam logic [1:0] MODE_LINEAR       = 2'd2;
  localparam logic [1:0] MODE_LINEAR_FUSED = 2'd3;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic signed [EW:0] BIAS_ADJ = 12'sd177;

  // value = man * 2^exp, man[MW-1] set when finite and nonzero
  typedef struct packed {
    logic          nan;
    logic          inf;
    logic          zero;
    logic          sgn;
    logic [MW-1:0] man;
    logic [EW-1:0] exp;
  } xv_t;

  function automatic logic [5:0] lzc(input logic [MW-1:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < MW; i++) begin
      if (v[i]) n = 6'(MW - 1 - i);
    end
    return n;
  endfunction

  function automatic xv_t unpack_norm(input logic [31:0] b);
    xv_t           r;
    logic [7:0]    be;
    logic [22:0]   fr;
    logic [MW-1:0] m;
    logic [5:0]    lz;
    logic [EW-1:0] e;
    be = b[30:23];
    fr = b[22:0];
    m  = {(be != 8'd0), fr, 27'd0};
    e  = (be == 8'd0) ? EW'(-176) : (EW'(be) - EW'(177));
    lz = lzc(m);
    r.nan  = (be == 8'hFF) && (fr != 23'd0);
    r.inf  = (be == 8'hFF) && (fr == 23'd0);
    r.zero = (be == 8'd0) && (fr == 23'd0);
    r.sgn  = b[31];
    r.man  = m << lz;
    r.exp  = e - EW'(lz);
    return r;
  endfunction

  function automatic logic [31:0] round_xv(input xv_t v);
    logic signed [EW:0] bn;
    logic [4:0]         sh;
    logic [MW+31:0]     t;
    logic [23:0]        kept;
    logic               rb;
    logic               st;
    logic               inc;
    logic [24:0]        k;
    logic [31:0]        r;
    bn = $signed({v.exp[EW-1], v.exp}) + BIAS_ADJ;
    if (bn > 0) sh = 5'd0;
    else if (bn < -30) sh = 5'd31;
    else sh = 5'(1 - bn);
    t    = {v.man, 32'd0} >> sh;
    kept = t[MW+31 -: 24];
    rb   = t[MW+7];
    st   = |t[MW+6:0];
    inc  = rb & (st | kept[0]);
    k    = {1'b0, kept} + 25'(inc);
    if (v.nan) r = QNAN;
    else if (v.inf) r = {v.sgn, 8'hFF, 23'd0};
    else if (v.zero) r = {v.sgn, 31'd0};
    else if (sh != 5'd0) r = {v.sgn, 7'd0, k[23], k[22:0]};
    else if ((bn > 254) || ((bn == 254) && k[24])) r = {v.sgn, 8'hFF, 23'd0};
    else r = {v.sgn, bn[7:0] + 8'(k[24]), (k[24] ? k[23:1] : k[22:0])};
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/avt_fmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avt_fmul
// Exact binary32 product in two stages: multiply, then normalize.
// ----------------------------------------------------------------------------
module avt_fmul import avt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output xv_t              p
);

  logic [7:0]    ea, eb;
  logic [23:0]   ma, mb;
  logic [EW-1:0] xa, xb;
  logic          a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic          nan_c, inf_c;

  logic [47:0]   prod_r;
  logic [EW-1:0] exp_r;
  logic          nan_r, inf_r, zero_r, sgn_r;
  xv_t           p_r;
  logic [MW-1:0] m2;
  logic [5:0]    lz2;

  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    ma     = {(ea != 8'd0), a[22:0]};
    mb     = {(eb != 8'd0), b[22:0]};
    xa     = (ea == 8'd0) ? EW'(-149) : (EW'(ea) - EW'(150));
    xb     = (eb == 8'd0) ? EW'(-149) : (EW'(eb) - EW'(150));
    a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
    a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
    a_zero = (ea == 8'd0) && (a[22:0] == 23'd0);
    b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
    b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
    b_zero = (eb == 8'd0) && (b[22:0] == 23'd0);
    nan_c  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    inf_c  = !nan_c && (a_inf | b_inf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= ma * mb;
      exp_r  <= xa + xb;
      nan_r  <= nan_c;
      inf_r  <= inf_c;
      zero_r <= !nan_c && !inf_c && (a_zero | b_zero);
      sgn_r  <= a[31] ^ b[31];
    end
  end

  always_comb begin
    m2  = {prod_r, 3'd0};
    lz2 = lzc(m2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r.nan  <= nan_r;
      p_r.inf  <= inf_r;
      p_r.zero <= zero_r;
      p_r.sgn  <= sgn_r;
      p_r.man  <= m2 << lz2;
      p_r.exp  <= exp_r - EW'(3) - EW'(lz2);
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== src/avt_fadd.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avt_fadd
// Exact sum of two normalized values, rounded once to binary32.
// Stages: align, add, normalize, round.
// ----------------------------------------------------------------------------
module avt_fadd import avt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire xv_t         a,
  input  wire xv_t         b,
  output logic [31:0]      sum
);

  logic          a_big;
  xv_t           big, sml;
  logic [EW-1:0] d;
  logic [MW-1:0] mask;
  logic [MW-1:0] sml_sh;

  logic          nan_a_r, inf_a_r, isgn_a_r, zz_a_r, zsgn_a_r, sgn_a_r, sub_a_r;
  logic [MW-1:0] bm_a_r, sm_a_r;
  logic [EW-1:0] exp_a_r;

  logic          nan_b_r, inf_b_r, isgn_b_r, zz_b_r, zsgn_b_r, sgn_b_r;
  logic [MW:0]   sum_b_r;
  logic [EW-1:0] exp_b_r;

  logic [5:0]    lz_c;
  xv_t           n_c;
  xv_t           n_r;
  logic [31:0]   sum_r;

  always_comb begin
    a_big = b.zero || (!a.zero && (($signed(a.exp) > $signed(b.exp)) ||
            ((a.exp == b.exp) && (a.man >= b.man))));
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    d     = big.exp - sml.exp;
    mask  = ~({MW{1'b1}} << d[5:0]);
    if (sml.zero) sml_sh = '0;
    else if (d >= EW'(MW)) sml_sh = MW'(1);
    else sml_sh = (sml.man >> d[5:0]) | MW'(|(sml.man & mask));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nan_a_r  <= a.nan | b.nan | (a.inf & b.inf & (a.sgn ^ b.sgn));
      inf_a_r  <= a.inf | b.inf;
      isgn_a_r <= a.inf ? a.sgn : b.sgn;
      zz_a_r   <= a.zero & b.zero;
      zsgn_a_r <= a.sgn & b.sgn;
      sgn_a_r  <= big.sgn;
      sub_a_r  <= big.sgn ^ sml.sgn;
      bm_a_r   <= big.man;
      sm_a_r   <= sml_sh;
      exp_a_r  <= big.exp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nan_b_r  <= nan_a_r;
      inf_b_r  <= inf_a_r;
      isgn_b_r <= isgn_a_r;
      zz_b_r   <= zz_a_r;
      zsgn_b_r <= zsgn_a_r;
      sgn_b_r  <= sgn_a_r;
      exp_b_r  <= exp_a_r;
      sum_b_r  <= sub_a_r ? ({1'b0, bm_a_r} - {1'b0, sm_a_r})
                          : ({1'b0, bm_a_r} + {1'b0, sm_a_r});
    end
  end

  always_comb begin
    lz_c     = lzc(sum_b_r[MW-1:0]);
    n_c.nan  = nan_b_r;
    n_c.inf  = !nan_b_r && inf_b_r;
    n_c.zero = !nan_b_r && !inf_b_r && (zz_b_r || (sum_b_r == '0));
    if (inf_b_r) n_c.sgn = isgn_b_r;
    else if (zz_b_r) n_c.sgn = zsgn_b_r;
    else if (sum_b_r == '0) n_c.sgn = 1'b0;
    else n_c.sgn = sgn_b_r;
    if (sum_b_r[MW]) begin
      n_c.man = {sum_b_r[MW:2], sum_b_r[1] | sum_b_r[0]};
      n_c.exp = exp_b_r + EW'(1);
    end else begin
      n_c.man = sum_b_r[MW-1:0] << lz_c;
      n_c.exp = exp_b_r - EW'(lz_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_c;
      sum_r <= round_xv(n_r);
    end
  end

  assign sum = sum_r;

endmodule
`default_nettype wire

// ===== src/avt_row.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avt_row
// One matrix row: three products, then four adders (two side by side, then
// two in a chain) whose operands follow the evaluation order of the mode.
// ----------------------------------------------------------------------------
module avt_row import avt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] ma,
  input  wire logic [31:0] mb,
  input  wire logic [31:0] mc,
  input  wire logic [31:0] mt,
  input  wire logic [31:0] x,
  input  wire logic [31:0] y,
  input  wire logic [31:0] z,
  output logic [31:0]      res
);

  xv_t         pa2, pb2, pc2;
  logic [31:0] ra3_r, rb3_r, rc3_r;
  xv_t         pa3_r, pc3_r;
  xv_t         ura4_r, urb4_r, urc4_r, ut4_r, pa4_r, pc4_r;
  xv_t         add1a_a, add1a_b;
  logic [31:0] sum1a, sum1b;
  xv_t         urb_d_r [ADD_LAT];
  xv_t         urc_d_r [ADD_LAT];
  xv_t         pc_d_r  [ADD_LAT];
  xv_t         s9_r, v9_r, urb9_r, urc9_r, pc9_r;
  xv_t         add2_a, add2_b;
  logic [31:0] sum2;
  xv_t         urc2_d_r [ADD_LAT];
  xv_t         s14_r, urc14_r;
  logic [31:0] r14_r;
  logic [31:0] r_d_r [ADD_LAT];
  logic [31:0] sum3;

  avt_fmul u_mul_a (.clk(clk), .en(en), .a(ma), .b(x), .p(pa2));
  avt_fmul u_mul_b (.clk(clk), .en(en), .a(mb), .b(y), .p(pb2));
  avt_fmul u_mul_c (.clk(clk), .en(en), .a(mc), .b(z), .p(pc2));

  always_ff @(posedge clk) begin
    if (en) begin
      ra3_r  <= round_xv(pa2);
      rb3_r  <= round_xv(pb2);
      rc3_r  <= round_xv(pc2);
      pa3_r  <= pa2;
      pc3_r  <= pc2;
      ura4_r <= unpack_norm(ra3_r);
      urb4_r <= unpack_norm(rb3_r);
      urc4_r <= unpack_norm(rc3_r);
      ut4_r  <= unpack_norm(mt);
      pa4_r  <= pa3_r;
      pc4_r  <= pc3_r;
    end
  end

  always_comb begin
    unique case (mode)
      MODE_PLAIN: begin
        add1a_a = ura4_r;
        add1a_b = ut4_r;
      end
      MODE_FUSED: begin
        add1a_a = pc4_r;
        add1a_b = ura4_r;
      end
      MODE_LINEAR: begin
        add1a_a = ura4_r;
        add1a_b = urb4_r;
      end
      default: begin
        add1a_a = pa4_r;
        add1a_b = urb4_r;
      end
    endcase
  end

  avt_fadd u_add1a (.clk(clk), .en(en), .a(add1a_a), .b(add1a_b), .sum(sum1a));
  avt_fadd u_add1b (.clk(clk), .en(en), .a(ut4_r), .b(urb4_r), .sum(sum1b));

  always_ff @(posedge clk) begin
    if (en) begin
      urb_d_r[0]  <= urb4_r;
      urc_d_r[0]  <= urc4_r;
      pc_d_r[0]   <= pc4_r;
      urc2_d_r[0] <= urc9_r;
      r_d_r[0]    <= r14_r;
      for (int i = 1; i < ADD_LAT; i++) begin
        urb_d_r[i]  <= urb_d_r[i-1];
        urc_d_r[i]  <= urc_d_r[i-1];
        pc_d_r[i]   <= pc_d_r[i-1];
        urc2_d_r[i] <= urc2_d_r[i-1];
        r_d_r[i]    <= r_d_r[i-1];
      end
      s9_r    <= unpack_norm(sum1a);
      v9_r    <= unpack_norm(sum1b);
      urb9_r  <= urb_d_r[ADD_LAT-1];
      urc9_r  <= urc_d_r[ADD_LAT-1];
      pc9_r   <= pc_d_r[ADD_LAT-1];
      s14_r   <= unpack_norm(sum2);
      r14_r   <= sum2;
      urc14_r <= urc2_d_r[ADD_LAT-1];
    end
  end

  always_comb begin
    unique case (mode)
      MODE_PLAIN: begin
        add2_a = s9_r;
        add2_b = urb9_r;
      end
      MODE_FUSED: begin
        add2_a = s9_r;
        add2_b = v9_r;
      end
      MODE_LINEAR: begin
        add2_a = s9_r;
        add2_b = urc9_r;
      end
      default: begin
        add2_a = pc9_r;
        add2_b = s9_r;
      end
    endcase
  end

  avt_fadd u_add2 (.clk(clk), .en(en), .a(add2_a), .b(add2_b), .sum(sum2));
  avt_fadd u_add3 (.clk(clk), .en(en), .a(s14_r), .b(urc14_r), .sum(sum3));

  assign res = (mode == MODE_PLAIN) ? sum3 : r_d_r[ADD_LAT-1];

endmodule
`default_nettype wire

// ===== src/affine_vector_transform_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_vector_transform_unit
// Transforms binary32 vectors by a configured 3x4 matrix.
//
// Input channel in_valid/in_ready carries vec_x, vec_y, vec_z; the output
// channel out_valid/out_ready carries out_x, out_y, out_z of rows 0..2.
// The matrix and mode are loaded through cfg_we/cfg_index/cfg_wdata, one
// 64-bit register per write; the user must write them only while no
// transaction is in flight, which the block itself does not enforce. There
// are 18 pipeline stages (multiply, normalize, round, unpack, three adders
// of four stages each with a repack stage between them), the first loaded
// at the accepting edge, then the output register. One transaction enters
// per cycle while in_ready is high, set by the fully pipelined arithmetic.
// Reset loads the identity matrix and mode 0 and empties the pipeline.
// When the receiver stalls, the output register holds; the pipeline keeps
// accepting until its last stage holds a transaction, then all stages
// freeze together and in_ready drops.
// ----------------------------------------------------------------------------
module affine_vector_transform_unit import avt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [31:0]       in_vec_x,
  input  wire logic [31:0]       in_vec_y,
  input  wire logic [31:0]       in_vec_z,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            out_x,
  output logic [31:0]            out_y,
  output logic [31:0]            out_z,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [63:0]       cfg_wdata
);

  logic [63:0]           mat_r [NUM_MAT];
  logic [1:0]            mode_r;
  logic [PIPE_DEPTH-1:0] v_r;
  logic                  en;
  logic [31:0]           row_res [3];
  logic                  out_valid_r;
  logic [31:0]           out_x_r, out_y_r, out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[REG_ROW0_C01] <= RST_ROW0_C01;
      mat_r[REG_ROW0_C23] <= RST_ROW0_C23;
      mat_r[REG_ROW1_C01] <= RST_ROW1_C01;
      mat_r[REG_ROW1_C23] <= RST_ROW1_C23;
      mat_r[REG_ROW2_C01] <= RST_ROW2_C01;
      mat_r[REG_ROW2_C23] <= RST_ROW2_C23;
      mode_r              <= MODE_PLAIN;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODE) begin
        mode_r <= cfg_wdata[1:0];
      end else if (cfg_index < REG_MODE) begin
        mat_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  assign en       = !v_r[PIPE_DEPTH-1] || !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    avt_row u_row (
      .clk  (clk),
      .en   (en),
      .mode (mode_r),
      .ma   (mat_r[2*r][31:0]),
      .mb   (mat_r[2*r][63:32]),
      .mc   (mat_r[2*r+1][31:0]),
      .mt   (mat_r[2*r+1][63:32]),
      .x    (in_vec_x),
      .y    (in_vec_y),
      .z    (in_vec_z),
      .res  (row_res[r])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= v_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_x_r <= row_res[0];
      out_y_r <= row_res[1];
      out_z_r <= row_res[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted transaction missing from first stage");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[PIPE_DEPTH-1] && !in_ready) |=> v_r[PIPE_DEPTH-1])
    else $error("last stage dropped a transaction while stalled");

endmodule
`default_nettype wire
